// File: rtl/core/assert_macros.svh
// Assertion macros shared by the rasterizer core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Clocked assertion, held off while reset is asserted
`define MCR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcr assertion failed");

// Clocked assertion, checked in reset too
`define MCR_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mcr assertion failed");

`else

`define MCR_ASSERT(label, clk, rst_n, prop)
`define MCR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: rtl/core/mcr_pkg.sv
package mcr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned ColorBits      = 8;
  localparam int unsigned CfgIdxBits     = 1;
  localparam int unsigned BeatBits       = 3;

  localparam int unsigned FrameColsReset = 640;
  localparam int unsigned FrameRowsReset = 480;

  // Midpoint constants
  localparam int unsigned DecInit  = 1;
  localparam int unsigned StepDiag = 5;
  localparam int unsigned StepSide = 3;

  localparam logic [CfgIdxBits-1:0] CfgFrameCols = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgFrameRows = 1'b1;

  localparam logic ActStart   = 1'b0;
  localparam logic ActAdvance = 1'b1;

  localparam logic [BeatBits-1:0] LastBeat = 3'd7;

  typedef enum logic [1:0] {
    KindAccept = 2'd0,
    KindReject = 2'd1,
    KindPixel  = 2'd2
  } kind_e;

  // kind, centre x/y, point x/y, colour, done
  function automatic int unsigned job_bits(input int unsigned coord_bits);
    return 2 + 4 * coord_bits + ColorBits + 1;
  endfunction

endpackage

// File: rtl/core/mcr_front.sv
module mcr_front #(
  parameter int unsigned CoordBits = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [mcr_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [CoordBits:0]                   cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 action_i,
  input  logic [CoordBits-1:0]                 center_x_i,
  input  logic [CoordBits-1:0]                 center_y_i,
  input  logic [CoordBits-1:0]                 circle_radius_i,
  input  logic [mcr_pkg::ColorBits-1:0]        pixel_color_i,
  output logic                                 job_valid_o,
  input  logic                                 job_ready_i,
  output logic [mcr_pkg::job_bits(CoordBits)-1:0] job_o
);
  import mcr_pkg::*;

  localparam int unsigned DecBits = CoordBits + 3;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CoordBits-1:0] cx;
    logic [CoordBits-1:0] cy;
    logic [CoordBits-1:0] px;
    logic [CoordBits-1:0] py;
    logic [ColorBits-1:0] color;
    logic                 done;
  } job_t;

  logic [CoordBits:0]   cols_q, rows_q;
  logic                 drawing_q;
  logic [CoordBits-1:0] x_q, y_q, cx_q, cy_q;
  logic [ColorBits-1:0] color_q;
  logic [DecBits-1:0]   dec_q;

  logic [CoordBits:0]   sum_x, sum_y;
  logic                 out_of_frame;
  logic                 dec_nonneg;
  logic [DecBits-1:0]   x_ext, y_ext, dec_step;
  logic                 step_done;
  logic                 accept, is_start;
  job_t                 job;

  always_comb begin
    sum_x = {1'b0, center_x_i} + {1'b0, circle_radius_i};
    sum_y = {1'b0, center_y_i} + {1'b0, circle_radius_i};
    out_of_frame = (sum_x >= cols_q) || (center_x_i < circle_radius_i) ||
                   (sum_y >= rows_q) || (center_y_i < circle_radius_i);

    dec_nonneg = ~dec_q[DecBits-1];
    x_ext = DecBits'(x_q);
    y_ext = DecBits'(y_q);
    if (dec_nonneg) begin
      dec_step  = ((x_ext - y_ext) << 1) + DecBits'(StepDiag);
      // x+1 > y-1
      step_done = ({1'b0, x_q} + (CoordBits + 1)'(1)) >= {1'b0, y_q};
    end else begin
      dec_step  = (x_ext << 1) + DecBits'(StepSide);
      step_done = x_q >= y_q;
    end
  end

  assign is_start    = action_i == ActStart;
  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && job_ready_i;
  // advance with no circle active is dropped here
  assign job_valid_o = in_valid_i && job_ready_i && (is_start || drawing_q);
  assign cfg_ready_o = 1'b1;

  always_comb begin
    job = '0;
    if (is_start) begin
      job.kind = out_of_frame ? KindReject : KindAccept;
    end else begin
      job.kind  = KindPixel;
      job.cx    = cx_q;
      job.cy    = cy_q;
      job.px    = x_q;
      job.py    = y_q;
      job.color = color_q;
      job.done  = step_done;
    end
  end

  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q    <= (CoordBits + 1)'(FrameColsReset);
      rows_q    <= (CoordBits + 1)'(FrameRowsReset);
      drawing_q <= 1'b0;
      x_q       <= '0;
      y_q       <= '0;
      cx_q      <= '0;
      cy_q      <= '0;
      color_q   <= '0;
      dec_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgFrameCols: cols_q <= cfg_data_i;
          CfgFrameRows: rows_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept && is_start) begin
        if (out_of_frame) begin
          drawing_q <= 1'b0;
        end else begin
          drawing_q <= 1'b1;
          cx_q      <= center_x_i;
          cy_q      <= center_y_i;
          color_q   <= pixel_color_i;
          x_q       <= '0;
          y_q       <= circle_radius_i;
          dec_q     <= DecBits'(DecInit) - DecBits'(circle_radius_i);
        end
      end else if (accept && drawing_q) begin
        dec_q <= dec_q + dec_step;
        x_q   <= x_q + CoordBits'(1);
        if (dec_nonneg) begin
          y_q <= y_q - CoordBits'(1);
        end
        if (step_done) begin
          drawing_q <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/core/mcr_queue.sv
module mcr_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);
  import mcr_pkg::*;

  localparam int unsigned Depth   = 2;
  localparam int unsigned PtrBits = $clog2(Depth);

  logic [Width-1:0]   mem_q [Depth];
  logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrBits:0]   count_q;
  logic               push, pop;

  assign push_ready_o = count_q != (PtrBits + 1)'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (PtrBits + 1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (PtrBits + 1)'(1);
      end
    end
  end

endmodule

// File: rtl/core/mcr_back.sv
module mcr_back #(
  parameter int unsigned CoordBits = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    job_valid_i,
  output logic                                    job_ready_o,
  input  logic [mcr_pkg::job_bits(CoordBits)-1:0] job_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [1:0]                              result_kind_o,
  output logic [CoordBits-1:0]                    pixel_x_o,
  output logic [CoordBits-1:0]                    pixel_y_o,
  output logic [mcr_pkg::ColorBits-1:0]           write_value_o,
  output logic                                    last_of_run_o,
  output logic                                    circle_done_o
);
  import mcr_pkg::*;

  typedef struct packed {
    logic [1:0]           kind;
    logic [CoordBits-1:0] cx;
    logic [CoordBits-1:0] cy;
    logic [CoordBits-1:0] px;
    logic [CoordBits-1:0] py;
    logic [ColorBits-1:0] color;
    logic                 done;
  } job_t;

  job_t                 job_q;
  logic                 busy_q;
  logic [BeatBits-1:0]  beat_q;
  logic                 out_valid_q;
  logic [1:0]           kind_q;
  logic [CoordBits-1:0] pix_x_q, pix_y_q;
  logic [ColorBits-1:0] value_q;
  logic                 last_q, done_q;

  logic                 last_beat, emit, load;
  logic [CoordBits-1:0] off_a, off_b, pix_x, pix_y;

  assign last_beat   = (job_q.kind != KindPixel) || (beat_q == LastBeat);
  assign emit        = busy_q && (!out_valid_q || out_ready_i);
  assign job_ready_o = !busy_q || (emit && last_beat);
  assign load        = job_valid_i && job_ready_o;

  // beat bit 2 swaps the octant pair, bits 0 and 1 mirror x and y
  always_comb begin
    off_a = beat_q[2] ? job_q.py : job_q.px;
    off_b = beat_q[2] ? job_q.px : job_q.py;
    pix_x = beat_q[0] ? job_q.cx - off_a : job_q.cx + off_a;
    pix_y = beat_q[1] ? job_q.cy - off_b : job_q.cy + off_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      beat_q      <= '0;
      job_q       <= '0;
      out_valid_q <= 1'b0;
      kind_q      <= '0;
      pix_x_q     <= '0;
      pix_y_q     <= '0;
      value_q     <= '0;
      last_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        kind_q      <= job_q.kind;
        pix_x_q     <= pix_x;
        pix_y_q     <= pix_y;
        value_q     <= job_q.color;
        last_q      <= last_beat;
        done_q      <= job_q.done;
        beat_q      <= beat_q + BeatBits'(1);
        if (last_beat) begin
          busy_q <= 1'b0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // take the next word when idle or in the cycle the last result is registered
      if (load) begin
        job_q  <= job_t'(job_i);
        busy_q <= 1'b1;
        beat_q <= '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign pixel_x_o     = pix_x_q;
  assign pixel_y_o     = pix_y_q;
  assign write_value_o = value_q;
  assign last_of_run_o = last_q;
  assign circle_done_o = done_q;

endmodule

// File: rtl/core/midpoint_circle_rasterizer_core.sv
// Channel   Direction  Handshake              Word
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data (frame cols, rows)
// in        in         in_valid/in_ready      action, center_x/y, circle_radius, pixel_color
// out       out        out_valid/out_ready    result_kind, pixel_x/y, write_value, flags
//
// A start word gives one result, an advance word eight (none if no circle is
// active), one per cycle from the single result register while out_ready holds.
// The front end classifies a word combinationally and passes it through a
// two-entry queue; it stalls input only when that queue is full.
// Reset loads a 640 by 480 frame and leaves no circle active.
`include "assert_macros.svh"

module midpoint_circle_rasterizer_core #(
  parameter int unsigned COORD_BITS = mcr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mcr_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [COORD_BITS:0]               cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              action_i,
  input  logic [COORD_BITS-1:0]             center_x_i,
  input  logic [COORD_BITS-1:0]             center_y_i,
  input  logic [COORD_BITS-1:0]             circle_radius_i,
  input  logic [mcr_pkg::ColorBits-1:0]     pixel_color_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [1:0]                        result_kind_o,
  output logic [COORD_BITS-1:0]             pixel_x_o,
  output logic [COORD_BITS-1:0]             pixel_y_o,
  output logic [mcr_pkg::ColorBits-1:0]     write_value_o,
  output logic                              last_of_run_o,
  output logic                              circle_done_o
);
  import mcr_pkg::*;

  localparam int unsigned JobBits = job_bits(COORD_BITS);

  logic               fq_valid, fq_ready;
  logic [JobBits-1:0] fq_data;
  logic               qb_valid, qb_ready;
  logic [JobBits-1:0] qb_data;

  mcr_front #(
    .CoordBits(COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .center_x_i     (center_x_i),
    .center_y_i     (center_y_i),
    .circle_radius_i(circle_radius_i),
    .pixel_color_i  (pixel_color_i),
    .job_valid_o    (fq_valid),
    .job_ready_i    (fq_ready),
    .job_o          (fq_data)
  );

  mcr_queue #(
    .Width(JobBits)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i (fq_data),
    .pop_valid_o (qb_valid),
    .pop_ready_i (qb_ready),
    .pop_data_o  (qb_data)
  );

  mcr_back #(
    .CoordBits(COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (qb_valid),
    .job_ready_o  (qb_ready),
    .job_i        (qb_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(result_kind_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .write_value_o(write_value_o),
    .last_of_run_o(last_of_run_o),
    .circle_done_o(circle_done_o)
  );

  `MCR_ASSERT(a_status_word_shape, clk_i, rst_ni, out_valid_o && (result_kind_o == KindAccept || result_kind_o == KindReject) |-> last_of_run_o && pixel_x_o == '0 && pixel_y_o == '0 && write_value_o == '0)
  `MCR_ASSERT_ALWAYS(a_done_on_pixels_only, clk_i, out_valid_o && circle_done_o |-> result_kind_o == KindPixel)
  `MCR_ASSERT(a_start_reaches_queue, clk_i, rst_ni, in_valid_i && in_ready_o && action_i == ActStart |=> qb_valid)

endmodule
